// ===== hw/rtl/cc3p_pkg.sv =====
// Shared widths, latencies and status codes of the circumcircle pipeline.
package cc3p_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_W      = 32;

  // front end widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SQP_W   = 2 * COORD_BITS;
  localparam int DET_W   = PROD_W + 1;
  localparam int SQ_W    = 2 * COORD_BITS + 1;
  localparam int PNUM_W  = DIFF_W + SQ_W + 1;
  localparam int NUM_W   = PNUM_W + 1;

  // divider
  localparam int DVD_W    = NUM_W + FRAC_BITS;
  localparam int DVS_W    = DET_W + 1;
  localparam int DIV_BITS = 4;
  localparam int DIV_STG  = (DVD_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DVP_W    = DIV_STG * DIV_BITS;
  localparam int QR_W     = DVP_W + 1;
  localparam int DIV_LAT  = DIV_STG + 1;

  // offset clamp
  localparam int MAG_W = 63;
  localparam int QC_W  = (QR_W > 64) ? QR_W : 64;
  localparam logic [MAG_W-1:0] OFF_LIMIT = MAG_W'(1) << 62;
  localparam int CX_W  = 66;

  // square root
  localparam int RAD_W     = 64;
  localparam int RT_W      = 32;
  localparam int RM_W      = 34;
  localparam int SQRT_BITS = 4;
  localparam int SQRT_STG  = RT_W / SQRT_BITS;
  localparam int SQRT_LAT  = SQRT_STG + 1;

  localparam int VLD_N = 5 + DIV_LAT + 3 + SQRT_LAT;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_SAT       = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p3x;
    logic signed [COORD_BITS-1:0] p3y;
    logic                         negx;
    logic                         negy;
    logic                         zero;
  } div_side_t;

  typedef struct packed {
    logic [OUT_W-1:0] cx;
    logic [OUT_W-1:0] cy;
    logic             csat;
    logic             rsat;
    logic             zero;
  } sqrt_side_t;

endpackage

// ===== hw/rtl/cc3p_div.sv =====
// Pipelined restoring divider with round-to-nearest, DIV_BITS quotient bits per stage.
module cc3p_div import cc3p_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [QR_W-1:0]  quotient
);

  logic [DVS_W-1:0] rem [DIV_STG];
  logic [DVP_W-1:0] wrd [DIV_STG];
  logic [DVS_W-1:0] dvs [DIV_STG];

  for (genvar k = 0; k < DIV_STG; k++) begin : g_stage
    logic [DVS_W-1:0] r_in;
    logic [DVP_W-1:0] w_in;
    logic [DVS_W-1:0] d_in;
    logic [DVS_W-1:0] r_nx;
    logic [DVP_W-1:0] w_nx;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign w_in = DVP_W'(dividend);
      assign d_in = divisor;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign w_in = wrd[k-1];
      assign d_in = dvs[k-1];
    end

    always_comb begin
      logic [DVS_W:0]   t;
      logic [DVS_W-1:0] r;
      logic [DVP_W-1:0] w;
      r = r_in;
      w = w_in;
      for (int j = 0; j < DIV_BITS; j++) begin
        t = {r, w[DVP_W-1]};
        w = w << 1;
        if (t >= {1'b0, d_in}) begin
          t    = t - {1'b0, d_in};
          w[0] = 1'b1;
        end
        r = t[DVS_W-1:0];
      end
      r_nx = r;
      w_nx = w;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= r_nx;
        wrd[k] <= w_nx;
        dvs[k] <= d_in;
      end
    end
  end

  // round up when twice the remainder reaches the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      quotient <= QR_W'(wrd[DIV_STG-1])
                + QR_W'({rem[DIV_STG-1], 1'b0} >= {1'b0, dvs[DIV_STG-1]});
    end
  end

endmodule

// ===== hw/rtl/cc3p_sqrt.sv =====
// Pipelined digit-by-digit integer square root with round-to-nearest.
module cc3p_sqrt import cc3p_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [RAD_W-1:0] radicand,
  output logic [RT_W:0]    root
);

  logic [RM_W-1:0]  rem [SQRT_STG];
  logic [RAD_W-1:0] wrd [SQRT_STG];
  logic [RT_W-1:0]  rt  [SQRT_STG];

  for (genvar k = 0; k < SQRT_STG; k++) begin : g_stage
    logic [RM_W-1:0]  m_in;
    logic [RAD_W-1:0] w_in;
    logic [RT_W-1:0]  q_in;
    logic [RM_W-1:0]  m_nx;
    logic [RAD_W-1:0] w_nx;
    logic [RT_W-1:0]  q_nx;

    if (k == 0) begin : g_first
      assign m_in = '0;
      assign w_in = radicand;
      assign q_in = '0;
    end else begin : g_next
      assign m_in = rem[k-1];
      assign w_in = wrd[k-1];
      assign q_in = rt[k-1];
    end

    always_comb begin
      logic [RM_W+1:0]  t;
      logic [RM_W+1:0]  trial;
      logic [RM_W-1:0]  m;
      logic [RAD_W-1:0] w;
      logic [RT_W-1:0]  q;
      m = m_in;
      w = w_in;
      q = q_in;
      for (int j = 0; j < SQRT_BITS; j++) begin
        t     = {m, w[RAD_W-1 -: 2]};
        trial = (RM_W+2)'({q, 2'b01});
        w     = w << 2;
        if (t >= trial) begin
          t = t - trial;
          q = {q[RT_W-2:0], 1'b1};
        end else begin
          q = {q[RT_W-2:0], 1'b0};
        end
        m = t[RM_W-1:0];
      end
      m_nx = m;
      w_nx = w;
      q_nx = q;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= m_nx;
        wrd[k] <= w_nx;
        rt[k]  <= q_nx;
      end
    end
  end

  // remainder above the root means the true root is nearer the next integer
  always_ff @(posedge clk) begin
    if (en) begin
      root <= (RT_W+1)'(rt[SQRT_STG-1])
            + (RT_W+1)'(rem[SQRT_STG-1] > RM_W'(rt[SQRT_STG-1]));
    end
  end

endmodule

// ===== hw/rtl/circumcircle_of_three_points.sv =====
// Top level of the circumcircle pipeline: centre and radius of the circle through three points.
//
// Usage
//   Input channel (in_valid / in_ready) carries one triple of signed integer points per beat.
//   Output channel (out_valid / out_ready) carries centre_x, centre_y (signed Q23.8),
//   circle_radius (unsigned Q24.8) and status: 0 valid, 1 collinear (all fields zero),
//   2 saturated (centre clamped to the int32 limits and/or radius to all ones).
//   Stages from input beat to output beat, each one registered:
//   5 front-end stages (differences, products, determinant, numerators, sign split),
//   16 divider stages (4 quotient bits each plus rounding), 3 stages of clamp, centre
//   and radius squares, 9 square-root stages (4 bits of root each plus rounding), and
//   the output register.
//   Throughput: one beat per cycle while the output beat is not held; every stage advances together.
//   Stall: while out_valid is high and out_ready low, the whole pipe holds and in_ready
//   drops; nothing is lost or repeated, and the output holds its beat.
//   Reset: rst (synchronous) clears every valid bit and out_valid; data registers
//   keep whatever they hold, which no valid bit points at.
module circumcircle_of_three_points import cc3p_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] first_x,
  input  logic signed [COORD_BITS-1:0] first_y,
  input  logic signed [COORD_BITS-1:0] second_x,
  input  logic signed [COORD_BITS-1:0] second_y,
  input  logic signed [COORD_BITS-1:0] third_x,
  input  logic signed [COORD_BITS-1:0] third_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      centre_x,
  output logic signed [OUT_W-1:0]      centre_y,
  output logic        [OUT_W-1:0]      circle_radius,
  output logic        [1:0]            status
);

  // Single advance enable: the pipe moves when the output slot is free or being taken.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [VLD_N-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[VLD_N-2:0], in_valid};
    end
  end

  // ---- stage 1: edge vectors relative to the third point
  logic signed [DIFF_W-1:0]     ax, ay, bx, by;
  logic signed [COORD_BITS-1:0] p3x1, p3y1;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax   <= DIFF_W'(first_x) - DIFF_W'(third_x);
      ay   <= DIFF_W'(first_y) - DIFF_W'(third_y);
      bx   <= DIFF_W'(second_x) - DIFF_W'(third_x);
      by   <= DIFF_W'(second_y) - DIFF_W'(third_y);
      p3x1 <= third_x;
      p3y1 <= third_y;
    end
  end

  // ---- stage 2: cross products and squares
  logic signed [PROD_W-1:0]     m_axby, m_aybx;
  logic        [SQP_W-1:0]      q_ax, q_ay, q_bx, q_by;
  logic signed [DIFF_W-1:0]     ax2, ay2, bx2, by2;
  logic signed [COORD_BITS-1:0] p3x2, p3y2;
  logic signed [PROD_W-1:0]     sqx_a, sqy_a, sqx_b, sqy_b;

  always_comb begin
    sqx_a = PROD_W'(ax) * PROD_W'(ax);
    sqy_a = PROD_W'(ay) * PROD_W'(ay);
    sqx_b = PROD_W'(bx) * PROD_W'(bx);
    sqy_b = PROD_W'(by) * PROD_W'(by);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axby <= PROD_W'(ax) * PROD_W'(by);
      m_aybx <= PROD_W'(ay) * PROD_W'(bx);
      q_ax   <= sqx_a[SQP_W-1:0];
      q_ay   <= sqy_a[SQP_W-1:0];
      q_bx   <= sqx_b[SQP_W-1:0];
      q_by   <= sqy_b[SQP_W-1:0];
      ax2    <= ax;
      ay2    <= ay;
      bx2    <= bx;
      by2    <= by;
      p3x2   <= p3x1;
      p3y2   <= p3y1;
    end
  end

  // ---- stage 3: determinant and squared lengths
  logic signed [DET_W-1:0]      det3;
  logic        [SQ_W-1:0]       sa, sb;
  logic signed [DIFF_W-1:0]     ax3, ay3, bx3, by3;
  logic signed [COORD_BITS-1:0] p3x3, p3y3;

  always_ff @(posedge clk) begin
    if (adv) begin
      det3 <= DET_W'(m_axby) - DET_W'(m_aybx);
      sa   <= SQ_W'(q_ax) + SQ_W'(q_ay);
      sb   <= SQ_W'(q_bx) + SQ_W'(q_by);
      ax3  <= ax2;
      ay3  <= ay2;
      bx3  <= bx2;
      by3  <= by2;
      p3x3 <= p3x2;
      p3y3 <= p3y2;
    end
  end

  // ---- stage 4: numerator products
  logic signed [PNUM_W-1:0]     p_bysa, p_aysb, p_axsb, p_bxsa;
  logic signed [DET_W-1:0]      det4;
  logic signed [COORD_BITS-1:0] p3x4, p3y4;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_bysa <= PNUM_W'(by3) * PNUM_W'(signed'({1'b0, sa}));
      p_aysb <= PNUM_W'(ay3) * PNUM_W'(signed'({1'b0, sb}));
      p_axsb <= PNUM_W'(ax3) * PNUM_W'(signed'({1'b0, sb}));
      p_bxsa <= PNUM_W'(bx3) * PNUM_W'(signed'({1'b0, sa}));
      det4   <= det3;
      p3x4   <= p3x3;
      p3y4   <= p3y3;
    end
  end

  // ---- stage 5: numerators to sign and magnitude, scale, divisor = |2*det|
  logic signed [NUM_W-1:0] numx, numy;
  logic        [NUM_W-1:0] magnx, magny;
  logic        [DET_W-1:0] magdet;
  logic        [DVD_W-1:0] dvdx, dvdy;
  logic        [DVS_W-1:0] dvs5;
  div_side_t               side5;

  always_comb begin
    numx   = NUM_W'(p_bysa) - NUM_W'(p_aysb);
    numy   = NUM_W'(p_axsb) - NUM_W'(p_bxsa);
    magnx  = numx[NUM_W-1] ? NUM_W'(-numx) : NUM_W'(numx);
    magny  = numy[NUM_W-1] ? NUM_W'(-numy) : NUM_W'(numy);
    magdet = det4[DET_W-1] ? DET_W'(-det4) : DET_W'(det4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvdx       <= DVD_W'(magnx) << FRAC_BITS;
      dvdy       <= DVD_W'(magny) << FRAC_BITS;
      dvs5       <= DVS_W'(magdet) << 1;
      side5.p3x  <= p3x4;
      side5.p3y  <= p3y4;
      side5.negx <= numx[NUM_W-1] ^ det4[DET_W-1];
      side5.negy <= numy[NUM_W-1] ^ det4[DET_W-1];
      side5.zero <= (det4 == '0);
    end
  end

  // ---- divider: offsets as rounded magnitudes; side data rides alongside
  logic [QR_W-1:0] qx, qy;
  div_side_t       dside [DIV_LAT];

  cc3p_div u_div_x (
    .clk      (clk),
    .en       (adv),
    .dividend (dvdx),
    .divisor  (dvs5),
    .quotient (qx)
  );

  cc3p_div u_div_y (
    .clk      (clk),
    .en       (adv),
    .dividend (dvdy),
    .divisor  (dvs5),
    .quotient (qy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dside[0] <= side5;
      for (int i = 1; i < DIV_LAT; i++) begin
        dside[i] <= dside[i-1];
      end
    end
  end

  // ---- stage 6: clamp offset magnitudes
  logic [QC_W-1:0]  qxe, qye;
  logic             bigx, bigy;
  logic [MAG_W-1:0] ux, uy;
  logic             big6;
  div_side_t        side6;

  always_comb begin
    qxe  = QC_W'(qx);
    qye  = QC_W'(qy);
    bigx = qxe > QC_W'(OFF_LIMIT);
    bigy = qye > QC_W'(OFF_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux    <= bigx ? OFF_LIMIT : qxe[MAG_W-1:0];
      uy    <= bigy ? OFF_LIMIT : qye[MAG_W-1:0];
      big6  <= bigx || bigy;
      side6 <= dside[DIV_LAT-1];
    end
  end

  // ---- stage 7: centre with saturation, squares of the offsets
  logic signed [CX_W-1:0]   cxf, cyf;
  logic                     cxs, cys;
  logic [OUT_W-1:0]         cx7, cy7;
  logic                     csat7, big7, fit7, zero7;
  logic [RAD_W-1:0]         sqx7, sqy7;
  logic [CX_W-OUT_W:0]      cxh, cyh;

  always_comb begin
    cxf = (CX_W'(side6.p3x) <<< FRAC_BITS)
        + (side6.negx ? -CX_W'(signed'({1'b0, ux})) : CX_W'(signed'({1'b0, ux})));
    cyf = (CX_W'(side6.p3y) <<< FRAC_BITS)
        + (side6.negy ? -CX_W'(signed'({1'b0, uy})) : CX_W'(signed'({1'b0, uy})));
    cxh = cxf[CX_W-1:OUT_W-1];
    cyh = cyf[CX_W-1:OUT_W-1];
    cxs = !((&cxh) || !(|cxh));
    cys = !((&cyh) || !(|cyh));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx7   <= cxs ? (cxf[CX_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}})
                   : cxf[OUT_W-1:0];
      cy7   <= cys ? (cyf[CX_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}})
                   : cyf[OUT_W-1:0];
      csat7 <= cxs || cys;
      fit7  <= (ux[MAG_W-1:RT_W] == '0) && (uy[MAG_W-1:RT_W] == '0);
      sqx7  <= RAD_W'(ux[RT_W-1:0]) * RAD_W'(ux[RT_W-1:0]);
      sqy7  <= RAD_W'(uy[RT_W-1:0]) * RAD_W'(uy[RT_W-1:0]);
      big7  <= big6;
      zero7 <= side6.zero;
    end
  end

  // ---- stage 8: squared radius, overflow check
  logic [RAD_W:0]   sum8;
  logic [RAD_W-1:0] rad8;
  sqrt_side_t       side8;

  always_comb begin
    sum8 = (RAD_W+1)'(sqx7) + (RAD_W+1)'(sqy7);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad8       <= sum8[RAD_W-1:0];
      side8.cx   <= cx7;
      side8.cy   <= cy7;
      side8.csat <= csat7 || big7;
      side8.rsat <= big7 || !fit7 || sum8[RAD_W];
      side8.zero <= zero7;
    end
  end

  // ---- square root
  logic [RT_W:0] root;
  sqrt_side_t    sside [SQRT_LAT];

  cc3p_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (rad8),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sside[0] <= side8;
      for (int i = 1; i < SQRT_LAT; i++) begin
        sside[i] <= sside[i-1];
      end
    end
  end

  // ---- output register: hold the beat until it is taken
  sqrt_side_t fin;
  logic       rsat_f;

  always_comb begin
    fin    = sside[SQRT_LAT-1];
    rsat_f = fin.rsat || root[RT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[VLD_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.zero) begin
        centre_x      <= '0;
        centre_y      <= '0;
        circle_radius <= '0;
        status        <= ST_COLLINEAR;
      end else begin
        centre_x      <= fin.cx;
        centre_y      <= fin.cy;
        circle_radius <= rsat_f ? {OUT_W{1'b1}} : root[OUT_W-1:0];
        status        <= (fin.csat || rsat_f) ? ST_SAT : ST_OK;
      end
    end
  end

  // ---- assertions
  a_collinear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_COLLINEAR |->
      centre_x == '0 && centre_y == '0 && circle_radius == '0)
    else $error("collinear result carries nonzero fields");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(vld))
    else $error("pipeline moved during a stall");

  a_held_output_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output beat is held");

  // check on the first edge after reset drops
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && vld == '0)
    else $error("valid bits survive reset");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the circumcircle pipeline.
`timescale 1ns / 100ps

module tb;
  import cc3p_pkg::*;

  typedef struct {
    logic signed [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3;
    bit                           hold;  // wait for the pipe to drain first
  } triple_t;

  typedef struct {
    logic [OUT_W-1:0] cx, cy, rad;
    status_t          st;
  } circle_t;

  localparam int WATCH_LIMIT = 3000;
  localparam int RAND_ITEMS  = 1400;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] first_x = '0, first_y = '0, second_x = '0;
  logic signed [COORD_BITS-1:0] second_y = '0, third_x = '0, third_y = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [OUT_W-1:0]      centre_x, centre_y;
  logic        [OUT_W-1:0]      circle_radius;
  logic        [1:0]            status;

  triple_t pending_triples[$];
  circle_t expected_circles[$];
  int      mismatch_cnt = 0;
  int      sent_cnt = 0;
  int      quiet_cycles = 0;
  bit      in_taken = 1'b0;

  circumcircle_of_three_points uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round num * 2^FRAC_BITS / den to nearest, ties away from zero; clamp at 2^62.
  function automatic longint round_div(logic signed [127:0] num, longint den,
                                       inout bit big);
    logic [127:0] m, d, q, r;
    bit           neg;
    neg = (num < 0) != (den < 0);
    m = (num < 0) ? -num : num;
    d = (den < 0) ? 128'(-den) : 128'(den);
    m = m << FRAC_BITS;
    q = m / d;
    r = m % d;
    if (r >= d - r) q = q + 1;
    if (q > (128'(1) << 62)) begin
      big = 1'b1;
      q = 128'(1) << 62;
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [127:0] floor_sqrt(logic [127:0] s);
    logic [127:0] r, t;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      t = r | (128'(1) << i);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] clamp32(logic signed [127:0] v, inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic circle_t predict_circle(triple_t t);
    longint          ax, ay, bx, by, det, sa, sb, ox, oy;
    logic signed [127:0] nx, ny;
    logic [127:0]    ux, uy, sum, r;
    bit              sat, big;
    circle_t         c;
    sat = 1'b0;
    big = 1'b0;
    ax = longint'(t.x1) - longint'(t.x3);
    ay = longint'(t.y1) - longint'(t.y3);
    bx = longint'(t.x2) - longint'(t.x3);
    by = longint'(t.y2) - longint'(t.y3);
    det = ax * by - ay * bx;
    if (det == 0) begin
      c.cx = '0; c.cy = '0; c.rad = '0; c.st = ST_COLLINEAR;
      return c;
    end
    sa = ax * ax + ay * ay;
    sb = bx * bx + by * by;
    nx = 128'(by) * 128'(sa) - 128'(ay) * 128'(sb);
    ny = 128'(ax) * 128'(sb) - 128'(bx) * 128'(sa);
    ox = round_div(nx, 2 * det, big);
    oy = round_div(ny, 2 * det, big);
    c.cx = clamp32(128'(longint'(t.x3)) * (128'sd1 << FRAC_BITS) + 128'(ox), sat);
    c.cy = clamp32(128'(longint'(t.y3)) * (128'sd1 << FRAC_BITS) + 128'(oy), sat);
    ux = (ox < 0) ? 128'(-ox) : 128'(ox);
    uy = (oy < 0) ? 128'(-oy) : 128'(oy);
    c.rad = '1;
    if (big || ux > 128'hFFFF_FFFF || uy > 128'hFFFF_FFFF) begin
      sat = 1'b1;
    end else begin
      sum = ux * ux + uy * uy;
      if (sum >= (128'(1) << 64)) begin
        sat = 1'b1;
      end else begin
        r = floor_sqrt(sum);
        if (sum - r * r > r) r = r + 1;
        if (r > 128'hFFFF_FFFF) sat = 1'b1;
        else c.rad = r[OUT_W-1:0];
      end
    end
    c.st = sat ? ST_SAT : ST_OK;
    return c;
  endfunction

  task automatic report_mismatch(string field, logic [OUT_W-1:0] got,
                                 logic [OUT_W-1:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
    mismatch_cnt++;
  endtask

  task automatic add_triple(int x1, int y1, int x2, int y2, int x3, int y3, bit hold);
    triple_t t;
    t.x1 = COORD_BITS'(x1);
    t.y1 = COORD_BITS'(y1);
    t.x2 = COORD_BITS'(x2);
    t.y2 = COORD_BITS'(y2);
    t.x3 = COORD_BITS'(x3);
    t.y3 = COORD_BITS'(y3);
    t.hold = hold;
    pending_triples.push_back(t);
  endtask

  // Idle percentages per phase: receiver lazy, then sender lazy, then none.
  function automatic int send_idle_pct();
    if (sent_cnt < 500) return 6;
    if (sent_cnt < 1000) return 64;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (sent_cnt < 500) return 64;
    if (sent_cnt < 1000) return 6;
    return 0;
  endfunction

  // Driver: advance to a new beat only once the current one was taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct());
      if (!in_valid || in_taken) begin
        if (pending_triples.size() > 0 &&
            !(pending_triples[0].hold && expected_circles.size() > 0) &&
            $urandom_range(99) >= send_idle_pct()) begin
          first_x  <= pending_triples[0].x1;
          first_y  <= pending_triples[0].y1;
          second_x <= pending_triples[0].x2;
          second_y <= pending_triples[0].y2;
          third_x  <= pending_triples[0].x3;
          third_y  <= pending_triples[0].y3;
          void'(pending_triples.pop_front());
          in_valid <= 1'b1;
          sent_cnt <= sent_cnt + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on every input beat, check every output beat.
  always @(posedge clk) begin
    triple_t t;
    circle_t want;
    in_taken <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      t.x1 = first_x; t.y1 = first_y; t.x2 = second_x;
      t.y2 = second_y; t.x3 = third_x; t.y3 = third_y; t.hold = 1'b0;
      expected_circles.push_back(predict_circle(t));
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_circles.size() == 0) begin
        report_mismatch("unexpected beat", OUT_W'(status), '0);
      end else begin
        want = expected_circles.pop_front();
        if (centre_x !== want.cx) report_mismatch("centre_x", centre_x, want.cx);
        if (centre_y !== want.cy) report_mismatch("centre_y", centre_y, want.cy);
        if (circle_radius !== want.rad)
          report_mismatch("circle_radius", circle_radius, want.rad);
        if (status !== want.st)
          report_mismatch("status", OUT_W'(status), OUT_W'(want.st));
      end
    end
  end

  // Watchdog: give up when no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", WATCH_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int kind, bx, by, dx, dy;
    // directed corners
    add_triple(0, 0, 4, 0, 0, 4, 0);                  // right angle
    add_triple(0, 4, 4, 0, 0, 0, 0);                  // right angle, reversed
    add_triple(0, 0, 10, 0, 5, 9, 0);                 // near equilateral
    add_triple(1, 1, 2, 2, 3, 3, 0);                  // collinear
    add_triple(7, -3, 7, -3, 7, -3, 0);               // all coincident
    add_triple(5, 5, 5, 5, -9, 2, 0);                 // two coincident
    add_triple(-3, 8, 12, 8, 0, -1, 0);               // horizontal edge
    add_triple(6, -2, 6, 11, -4, 0, 0);               // vertical edge
    add_triple(-32768, -32768, 32767, -32768, -32768, 32767, 0);
    add_triple(32767, 32767, -32768, 32767, 32767, -32768, 0);
    add_triple(-32768, 32767, 32767, 32767, 32767, -32768, 0);
    add_triple(0, 0, 1, 0, 32767, 1, 0);              // det 1, centre saturates
    add_triple(-32768, -32768, 32767, 32767, 32766, 32767, 0);
    add_triple(-32768, 0, 32767, 1, 0, -32768, 0);
    add_triple(1, 0, 0, 1, -1, 0, 0);                 // small circle
    add_triple(0, 0, 1, 1, 2, 0, 0);
    add_triple(100, 200, -300, 50, 17, -999, 1);      // drains the pipe first
    add_triple(-1, -1, -1, 1, 1, -1, 0);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        add_triple($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                   i == 700);
      end else if (kind < 70) begin
        add_triple(int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                   int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                   int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64, 0);
      end else begin
        // collinear or nearly so: drives det to zero or to tiny values
        bx = int'($urandom_range(16000)) - 8000;
        by = int'($urandom_range(16000)) - 8000;
        dx = int'($urandom_range(8000)) - 4000;
        dy = int'($urandom_range(8000)) - 4000;
        add_triple(bx, by, bx + dx, by + dy,
                   bx + 2 * dx + int'($urandom_range(2)) - 1,
                   by + 2 * dy + ((kind < 85) ? int'($urandom_range(2)) - 1 : 0), 0);
      end
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pending_triples.size() == 0 && !in_valid);
    wait (expected_circles.size() == 0);
    repeat (VLD_N + 10) @(posedge clk);
    if (mismatch_cnt == 0 && expected_circles.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
